>>> rtl/core/trapezoid_fuzzifier_assert.svh
// assertion macros shared by the trapezoid fuzzifier rtl
`ifndef TRAPEZOID_FUZZIFIER_ASSERT_SVH
`define TRAPEZOID_FUZZIFIER_ASSERT_SVH

// condition holds at every edge out of reset
`define TF_ASSERT_HOLD(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("tf assertion failed: invariant");

// consequent holds in the same cycle as the antecedent
`define TF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tf assertion failed: implication");

// consequent holds in the cycle after the antecedent
`define TF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tf assertion failed: next cycle");

`endif

>>> rtl/core/tf_pkg.sv
// shared types and constants of the trapezoid fuzzifier
package tf_pkg;

  localparam int SET_COUNT    = 4;
  localparam int SAMPLE_WIDTH = 16;

  localparam int NUM_REGS   = 8;
  localparam int REG_W      = 16;
  localparam int REG_IDX_W  = 3;
  localparam int CFG_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int QUOT_W     = 15;
  localparam int DIV_STEPS  = QUOT_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [REG_W-1:0]  bound_t;
  typedef logic [1:0]        set_idx_t;
  typedef logic [QUOT_W-1:0] quot_t;
  typedef logic [NUM_REGS-1:0][REG_W-1:0] cfg_bank_t;

  localparam logic [31:0] SAMPLE_MASK32 =
    (SAMPLE_WIDTH >= 32) ? 32'hFFFF_FFFF : ((32'd1 << SAMPLE_WIDTH) - 32'd1);
  localparam bound_t SAMPLE_MASK = SAMPLE_MASK32[REG_W-1:0];

  localparam bound_t   ONE_Q15  = 16'd32768;
  localparam bound_t   ZERO_Q15 = 16'd0;
  localparam set_idx_t FIRST_SET = 2'd0;
  localparam set_idx_t LAST_SET  = set_idx_t'(SET_COUNT - 1);

  localparam cfg_bank_t CFG_RESET = {
    16'd65535, 16'd49152, 16'd40959, 16'd32768,
    16'd24575, 16'd16384, 16'd8191,  16'd0
  };

  typedef struct packed {
    logic   start;
    bound_t gap_dist;
    bound_t span;
  } div_req_t;

  typedef struct packed {
    logic  done;
    quot_t quot;
  } div_rsp_t;

endpackage

>>> rtl/core/tf_if.sv
// stream interfaces for the sample and membership beats
interface tf_in_if;
  logic           valid;
  logic           ready;
  tf_pkg::bound_t crisp_value;

  modport source (output valid, output crisp_value, input ready);
  modport sink (input valid, input crisp_value, output ready);
endinterface

interface tf_out_if;
  logic             valid;
  logic             ready;
  tf_pkg::set_idx_t set_index;
  tf_pkg::bound_t   degree;
  logic             last_of_run;

  modport source (output valid, output set_index, output degree, output last_of_run,
                  input ready);
  modport sink (input valid, input set_index, input degree, input last_of_run,
                output ready);
endinterface

>>> rtl/core/tf_cfg_regs.sv
// apb register bank holding the plateau bounds
module tf_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [tf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [tf_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [tf_pkg::APB_DATA_W-1:0]    prdata,
  output logic                             pready,
  output tf_pkg::cfg_bank_t                regs_o
);
  import tf_pkg::*;

  cfg_bank_t               regs_q;
  logic [REG_IDX_W-1:0]    idx;
  logic                    wr_en;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= CFG_RESET;
    end else if (wr_en) begin
      regs_q[idx] <= pwdata[REG_W-1:0];
    end
  end

  assign prdata = {{(APB_DATA_W-REG_W){1'b0}}, regs_q[idx]};
  assign regs_o = regs_q;

endmodule

>>> rtl/core/tf_divider.sv
// shared restoring divider, one quotient bit a cycle, gap_dist < span
module tf_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tf_pkg::div_req_t req_i,
  output tf_pkg::div_rsp_t rsp_o
);
  import tf_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  bound_t               rem_q, rem_d;
  bound_t               span_q, span_d;
  quot_t                quot_q, quot_d;
  logic [REG_W:0]       shifted;
  logic [REG_W:0]       trial;
  logic                 fits;

  // remainder stays below span, so one spare bit covers the doubling
  assign shifted = {rem_q, 1'b0};
  assign trial   = shifted - {1'b0, span_q};
  assign fits    = (shifted >= {1'b0, span_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    span_d = span_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = req_i.gap_dist;
      span_d = req_i.span;
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = fits ? trial[REG_W-1:0] : shifted[REG_W-1:0];
      quot_d = {quot_q[QUOT_W-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      span_q <= '0;
      quot_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      span_q <= span_d;
      quot_q <= quot_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> rtl/core/trapezoid_fuzzifier.sv
// trapezoid fuzzifier top: per-set sequencer around one shared divider
// each set goes to its beat straight from eval (plateau, end or zero) or through the divider (ramp)
// the ramp path waits on the 15-step divider; the beats of a sample come out one set at a time
// a new sample is taken only after the last set's beat of the previous sample is taken
// reset: bounds return to their default row, sequencer and divider go idle
`include "trapezoid_fuzzifier_assert.svh"

module trapezoid_fuzzifier (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tf_in_if.sink                         in_i,
  tf_out_if.source                      out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tf_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [tf_pkg::APB_DATA_W-1:0] pwdata,
  output logic [tf_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import tf_pkg::*;

  // idle waits for a sample, eval classifies one set, div waits on the
  // shared divider, out holds the beat until the sink takes it
  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_DIV,
    S_OUT
  } state_e;

  state_e    state_q, state_d;
  set_idx_t  idx_q, idx_d;
  bound_t    x_q, x_d;
  bound_t    degree_q, degree_d;
  logic      rising_q, rising_d;

  cfg_bank_t regs;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  // bounds of the current set and its neighbours
  logic [REG_IDX_W-1:0] lo_idx, hi_idx, pm_idx, nm_idx;
  bound_t lo, hi, pm, nm;

  // classification of the current set
  logic   need_div;
  logic   rising;
  bound_t fixed_deg;
  bound_t gap_dist;
  bound_t span;

  tf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .regs_o  (regs)
  );

  tf_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // register indices wrap modulo the bank, as the outer neighbours of the first and last sets are never used
  assign lo_idx = {idx_q, 1'b0};
  assign hi_idx = {idx_q, 1'b1};
  assign pm_idx = {idx_q, 1'b0} - 3'd1;
  assign nm_idx = {idx_q, 1'b0} + 3'd2;

  assign lo = regs[lo_idx];
  assign hi = regs[hi_idx];
  assign pm = regs[pm_idx];
  assign nm = regs[nm_idx];

  // one set per pass: plateau, end set, beyond the neighbour's bound, or a ramp
  always_comb begin
    need_div  = 1'b0;
    rising    = 1'b0;
    fixed_deg = ONE_Q15;
    gap_dist  = x_q - pm;
    span      = lo - pm;
    if (x_q >= lo && x_q <= hi) begin
      fixed_deg = ONE_Q15;
    end else if (x_q < lo) begin
      // rising side, gap after the previous set's high bound
      if (idx_q == FIRST_SET) begin
        fixed_deg = ONE_Q15;
      end else if (x_q <= pm) begin
        fixed_deg = ZERO_Q15;
      end else begin
        need_div = 1'b1;
        rising   = 1'b1;
      end
    end else begin
      // falling side, gap before the next set's low bound
      gap_dist = x_q - hi;
      span     = nm - hi;
      if (idx_q == LAST_SET) begin
        fixed_deg = ONE_Q15;
      end else if (x_q >= nm) begin
        fixed_deg = ZERO_Q15;
      end else begin
        need_div = 1'b1;
      end
    end
  end

  assign div_req.start    = (state_q == S_EVAL) && need_div;
  assign div_req.gap_dist = gap_dist;
  assign div_req.span     = span;

  always_comb begin
    state_d  = state_q;
    idx_d    = idx_q;
    x_d      = x_q;
    degree_d = degree_q;
    rising_d = rising_q;
    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          x_d     = in_i.crisp_value & SAMPLE_MASK;
          idx_d   = FIRST_SET;
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        if (need_div) begin
          rising_d = rising;
          state_d  = S_DIV;
        end else begin
          degree_d = fixed_deg;
          state_d  = S_OUT;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          degree_d = rising_q ? {1'b0, div_rsp.quot} : (ONE_Q15 - {1'b0, div_rsp.quot});
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_o.ready) begin
          if (idx_q == LAST_SET) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = S_EVAL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      idx_q    <= FIRST_SET;
      x_q      <= '0;
      degree_q <= '0;
      rising_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      x_q      <= x_d;
      degree_q <= degree_d;
      rising_q <= rising_d;
    end
  end

  // one beat per set, held in registers until taken
  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.set_index   = idx_q;
  assign out_o.degree      = degree_q;
  assign out_o.last_of_run = (idx_q == LAST_SET);

  `TF_ASSERT_IMP(a_degree_range, clk_i, rst_ni, out_o.valid, out_o.degree <= ONE_Q15)
  `TF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_i.valid && in_i.ready, !in_i.ready)
  `TF_ASSERT_NEXT(a_idle_after_last, clk_i, rst_ni, out_o.valid && out_o.ready && out_o.last_of_run, in_i.ready)
  `TF_ASSERT_HOLD(a_no_overlap, clk_i, rst_ni, !(in_i.ready && out_o.valid))

endmodule
